FILE: src/osrs_pkg.sv
// ----------------------------------------------------------------------------
// osrs_pkg
// Shared constants, codes and types for the ordered set rank/select unit.
// ----------------------------------------------------------------------------
package osrs_pkg;

	localparam int CAPACITY = 64;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_KTH    = 2'd2;
	localparam logic [1:0] FUNC_COUNT  = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOCHG   = 2'd1;
	localparam logic [1:0] ST_BADRANK = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_SCMP,
		S_DECIDE,
		S_KCHK,
		S_KRD,
		S_SHRD,
		S_SHWR,
		S_FIN,
		S_RESP
	} state_t;

endpackage

FILE: src/ordered_set_rank_select_unit.sv
// ----------------------------------------------------------------------------
// ordered_set_rank_select_unit
// Sorted set of distinct signed keys with insert, delete, k-th and count.
// ----------------------------------------------------------------------------
// Keys live ascending in one synchronous RAM (one read, one write per cycle,
// read data registered, in the cycle after its address). One item is worked
// at a time; it is taken in the idle state. Insert, delete and count run a
// binary search over the RAM: each probe issues a read, then compares the
// data with the key, for at most ceil(log2(size+1)) probes, and the search
// ends once its bounds meet. A decide state then settles the outcome. Insert
// and delete move each entry above the key by one slot, a read and then a
// write per moved entry, and then a final state writes the key and grows the
// size, or shrinks the size. K-th takes a range check, then one RAM read; an
// invalid rank skips the read. Every item ends in a state that loads the
// result into the output register; it waits while the previous result is still
// waiting there. The next item is taken once the result has been loaded.
module ordered_set_rank_select_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [31:0] key,
	input  logic [6:0]         rank,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] kth_value,
	output logic [6:0]         smaller_count,
	output logic [1:0]         status
);

	localparam int AW = osrs_pkg::AW;
	localparam int CW = osrs_pkg::CW;

	logic [31:0] mem [osrs_pkg::CAPACITY];
	logic [31:0] rdata;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	osrs_pkg::state_t state_q, state_d;
	logic [1:0]  func_q, func_d;
	logic signed [31:0] key_q, key_d;
	logic [6:0]  rank_q, rank_d;
	logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d, size_q, size_d;
	logic        found_q, found_d;
	logic [31:0] rkth_q, rkth_d;
	logic [CW-1:0] rcnt_q, rcnt_d;
	logic [1:0]  rst_q, rst_d;
	logic        ov_q, ov_d;
	logic [31:0] okth_q, okth_d;
	logic [6:0]  ocnt_q, ocnt_d;
	logic [1:0]  ost_q, ost_d;
	logic [CW:0] sum;
	logic [CW-1:0] mid;

	assign sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = sum[CW:1];

	always_comb begin
		state_d = state_q;
		func_d = func_q; key_d = key_q; rank_d = rank_q;
		lo_d = lo_q; hi_d = hi_q; idx_d = idx_q; size_d = size_q;
		found_d = found_q;
		rkth_d = rkth_q; rcnt_d = rcnt_q; rst_d = rst_q;
		ov_d = ov_q; okth_d = okth_q; ocnt_d = ocnt_q; ost_d = ost_q;
		we = 1'b0; waddr = '0; wdata = key_q; raddr = '0;
		in_ready = (state_q == osrs_pkg::S_IDLE);
		if (ov_q && out_ready) ov_d = 1'b0;
		case (state_q)
			osrs_pkg::S_IDLE: begin
				if (in_valid) begin
					func_d = func; key_d = key; rank_d = rank;
					lo_d = '0; hi_d = size_q; found_d = 1'b0;
					rkth_d = '0; rcnt_d = '0; rst_d = osrs_pkg::ST_DONE;
					state_d = (func == osrs_pkg::FUNC_KTH) ? osrs_pkg::S_KCHK
						: osrs_pkg::S_SRCH;
				end
			end
			osrs_pkg::S_SRCH: begin
				if (lo_q < hi_q) begin
					raddr = AW'(mid);
					state_d = osrs_pkg::S_SCMP;
				end else begin
					state_d = osrs_pkg::S_DECIDE;
				end
			end
			osrs_pkg::S_SCMP: begin
				if ($signed(rdata) < key_q) begin
					lo_d = mid + CW'(1);
				end else begin
					hi_d = mid;
					if (rdata == key_q) found_d = 1'b1;
				end
				state_d = osrs_pkg::S_SRCH;
			end
			osrs_pkg::S_DECIDE: begin
				state_d = osrs_pkg::S_RESP;
				case (func_q)
					osrs_pkg::FUNC_INSERT: begin
						if (found_q) rst_d = osrs_pkg::ST_NOCHG;
						else if (int'(size_q) >= osrs_pkg::CAPACITY)
							rst_d = osrs_pkg::ST_FULL;
						else begin
							idx_d = size_q;
							state_d = (size_q > lo_q) ? osrs_pkg::S_SHRD
								: osrs_pkg::S_FIN;
						end
					end
					osrs_pkg::FUNC_DELETE: begin
						if (!found_q) rst_d = osrs_pkg::ST_NOCHG;
						else begin
							idx_d = lo_q;
							state_d = ({1'b0, lo_q} + (CW+1)'(1) < {1'b0, size_q})
								? osrs_pkg::S_SHRD : osrs_pkg::S_FIN;
						end
					end
					default: rcnt_d = lo_q;
				endcase
			end
			osrs_pkg::S_KCHK: begin
				if (rank_q == 7'd0 || int'(rank_q) > int'(size_q)) begin
					rst_d = osrs_pkg::ST_BADRANK;
					state_d = osrs_pkg::S_RESP;
				end else begin
					raddr = AW'(rank_q - 7'd1);
					state_d = osrs_pkg::S_KRD;
				end
			end
			osrs_pkg::S_KRD: begin
				rkth_d = rdata;
				state_d = osrs_pkg::S_RESP;
			end
			osrs_pkg::S_SHRD: begin
				raddr = (func_q == osrs_pkg::FUNC_INSERT) ? AW'(idx_q - CW'(1))
					: AW'(idx_q + CW'(1));
				state_d = osrs_pkg::S_SHWR;
			end
			osrs_pkg::S_SHWR: begin
				we = 1'b1; waddr = AW'(idx_q); wdata = rdata;
				if (func_q == osrs_pkg::FUNC_INSERT) begin
					idx_d = idx_q - CW'(1);
					state_d = (idx_q - CW'(1) > lo_q) ? osrs_pkg::S_SHRD
						: osrs_pkg::S_FIN;
				end else begin
					idx_d = idx_q + CW'(1);
					state_d = ({1'b0, idx_q} + (CW+1)'(2) < {1'b0, size_q})
						? osrs_pkg::S_SHRD : osrs_pkg::S_FIN;
				end
			end
			osrs_pkg::S_FIN: begin
				if (func_q == osrs_pkg::FUNC_INSERT) begin
					we = 1'b1; waddr = AW'(lo_q); wdata = key_q;
					size_d = size_q + CW'(1);
				end else begin
					size_d = size_q - CW'(1);
				end
				state_d = osrs_pkg::S_RESP;
			end
			osrs_pkg::S_RESP: begin
				if (!ov_q || out_ready) begin
					ov_d = 1'b1; okth_d = rkth_q; ocnt_d = 7'(rcnt_q); ost_d = rst_q;
					state_d = osrs_pkg::S_IDLE;
				end
			end
			default: state_d = osrs_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osrs_pkg::S_IDLE;
			size_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			size_q <= size_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d; key_q <= key_d; rank_q <= rank_d;
		lo_q <= lo_d; hi_q <= hi_d; idx_q <= idx_d; found_q <= found_d;
		rkth_q <= rkth_d; rcnt_q <= rcnt_d; rst_q <= rst_d;
		okth_q <= okth_d; ocnt_q <= ocnt_d; ost_q <= ost_d;
	end

	assign out_valid = ov_q;
	assign kth_value = okth_q;
	assign smaller_count = ocnt_q;
	assign status = ost_q;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, delete, k-th and count items into the ordered set unit and
// checks every result against a sorted-queue model of the set.
// ----------------------------------------------------------------------------
module tb_top;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         func = osrs_pkg::FUNC_COUNT;
	logic signed [31:0] key = '0;
	logic [6:0]         rank = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] kth_value;
	logic [6:0]         smaller_count;
	logic [1:0]         status;

	typedef struct packed {
		logic signed [31:0] kth;
		logic [6:0]         cnt;
		logic [1:0]         st;
	} answer_t;

	logic signed [31:0] set_keys[$];
	answer_t            answers[$];
	int                 errors = 0;
	int                 send_idle = 0;
	int                 recv_stall = 0;
	int                 hold_req = 0;
	int                 hold_cycles = 0;
	logic signed [31:0] pool[16];

	ordered_set_rank_select_unit dut (.*);

	always #4 clk = ~clk;

	function automatic answer_t apply_op(logic [1:0] f, logic signed [31:0] k,
			logic [6:0] r);
		answer_t a;
		int      pos;
		bit      hit;
		a = '0;
		pos = 0;
		foreach (set_keys[i]) if (set_keys[i] < k) pos++;
		hit = (pos < set_keys.size()) && (set_keys[pos] == k);
		case (f)
			osrs_pkg::FUNC_INSERT: begin
				if (hit) a.st = osrs_pkg::ST_NOCHG;
				else if (set_keys.size() >= osrs_pkg::CAPACITY) a.st = osrs_pkg::ST_FULL;
				else set_keys.insert(pos, k);
			end
			osrs_pkg::FUNC_DELETE: begin
				if (!hit) a.st = osrs_pkg::ST_NOCHG;
				else set_keys.delete(pos);
			end
			osrs_pkg::FUNC_KTH: begin
				if (r == 0 || r > set_keys.size()) a.st = osrs_pkg::ST_BADRANK;
				else a.kth = set_keys[r - 1];
			end
			default: a.cnt = pos[6:0];
		endcase
		return a;
	endfunction

	task automatic send_item(logic [1:0] f, logic signed [31:0] k, logic [6:0] r);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		func <= f;
		key <= k;
		rank <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		answers.push_back(apply_op(f, k, r));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (answers.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_req - 1;
			hold_req = 0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			if (answers.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: result with no item pending");
			end else begin
				e = answers.pop_front();
				if (e.kth !== kth_value || e.cnt !== smaller_count || e.st !== status) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: exp kth=%0d cnt=%0d st=%0d got kth=%0d cnt=%0d st=%0d",
							e.kth, e.cnt, e.st, kth_value, smaller_count, status);
				end
			end
		end
	end

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom;
			default: return pool[$urandom_range(15)];
		endcase
	endfunction

	task automatic test_directed();
		send_item(osrs_pkg::FUNC_KTH, 0, 1);
		send_item(osrs_pkg::FUNC_DELETE, 5, 0);
		send_item(osrs_pkg::FUNC_COUNT, 32'sh8000_0000, 0);
		send_item(osrs_pkg::FUNC_INSERT, 32'sh8000_0000, 0);
		send_item(osrs_pkg::FUNC_INSERT, 32'sh7fff_ffff, 0);
		send_item(osrs_pkg::FUNC_INSERT, 0, 0);
		send_item(osrs_pkg::FUNC_INSERT, -1, 0);
		send_item(osrs_pkg::FUNC_INSERT, 0, 0);
		send_item(osrs_pkg::FUNC_COUNT, 32'sh8000_0000, 0);
		send_item(osrs_pkg::FUNC_COUNT, 32'sh7fff_ffff, 0);
		send_item(osrs_pkg::FUNC_COUNT, 1, 0);
		send_item(osrs_pkg::FUNC_KTH, 0, 0);
		send_item(osrs_pkg::FUNC_KTH, 0, 1);
		send_item(osrs_pkg::FUNC_KTH, 0, 4);
		send_item(osrs_pkg::FUNC_KTH, 0, 5);
		send_item(osrs_pkg::FUNC_KTH, -1, 7'h7f);
		send_item(osrs_pkg::FUNC_DELETE, 0, 7'h7f);
		send_item(osrs_pkg::FUNC_DELETE, 0, 0);
		send_item(osrs_pkg::FUNC_KTH, 32'h5555_aaaa, 7'h55);
		send_item(osrs_pkg::FUNC_KTH, 32'haaaa_5555, 7'h2a);
	endtask

	task automatic test_full_set();
		for (int i = 0; i < 70; i++) send_item(osrs_pkg::FUNC_INSERT, $urandom, 0);
		send_item(osrs_pkg::FUNC_INSERT, set_keys[3], 0);
		send_item(osrs_pkg::FUNC_INSERT, 32'sh7fff_fff0, 0);
		send_item(osrs_pkg::FUNC_KTH, 0, 64);
		send_item(osrs_pkg::FUNC_KTH, 0, 65);
		send_item(osrs_pkg::FUNC_COUNT, 32'sh7fff_ffff, 0);
		while (set_keys.size() > 0) send_item(osrs_pkg::FUNC_DELETE, set_keys[$], 0);
	endtask

	task automatic test_random(int n);
		logic [1:0] f;
		for (int i = 0; i < n; i++) begin
			f = 2'($urandom_range(3));
			if (set_keys.size() > 48 && f == osrs_pkg::FUNC_INSERT && $urandom_range(1))
				f = osrs_pkg::FUNC_DELETE;
			send_item(f, pick_key(), 7'($urandom_range(0, 70)));
		end
	endtask

	task automatic test_backpressure();
		hold_req = 400;
		for (int i = 0; i < 12; i++)
			send_item(2'($urandom_range(3)), pick_key(), 7'($urandom_range(1, 8)));
		drain();
		for (int i = 0; i < 12; i++)
			send_item(2'($urandom_range(3)), pick_key(), 7'($urandom_range(1, 8)));
	endtask

	initial begin
		foreach (pool[i]) pool[i] = $urandom;
		pool[0] = 32'sh8000_0000;
		pool[1] = 32'sh7fff_ffff;
		pool[2] = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_full_set();
		test_random(200);
		send_idle = 51;
		test_random(200);
		send_idle = 0;
		recv_stall = 51;
		test_random(200);
		send_idle = 29;
		recv_stall = 29;
		test_random(200);
		send_idle = 0;
		recv_stall = 0;
		test_backpressure();
		test_random(100);
		drain();
		if (errors == 0 && answers.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
